@@ rtl/sphc_pkg.sv @@
// Package for the stepper position and homing controller.
// Holds the item, configuration and state types, codes and constants.
// It depends on nothing and is used by every file of the block.
package sphc_pkg;

  localparam int unsigned PosW      = 16;
  localparam int unsigned RemW      = 18;
  localparam int unsigned AmountW   = 17;
  localparam int unsigned IntervalW = 14;
  localparam int unsigned PercentW  = 7;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned CfgIdxW   = 3;

  // Speed mapping: interval = slow interval - step * percent.
  localparam logic [IntervalW-1:0] INTERVAL_SLOW  = 14'd10000;
  localparam logic [IntervalW-1:0] INTERVAL_FAST  = 14'd400;
  localparam logic [IntervalW-1:0] SPEED_STEP     = 14'd96;
  localparam logic [PercentW-1:0]  SPEED_MAX      = 7'd100;

  localparam logic signed [RemW-1:0] REM_MAX = 18'sh1FFFF;
  localparam logic signed [RemW-1:0] REM_MIN = 18'sh20000;

  // Reset values of the configuration registers.
  localparam logic signed [PosW-1:0] RST_PRESET_REST    = -16'sd2000;
  localparam logic signed [PosW-1:0] RST_PRESET_UPRIGHT = -16'sd2792;
  localparam logic signed [PosW-1:0] RST_PRESET_KNOCKED = -16'sd4450;
  localparam logic signed [PosW-1:0] RST_PRESET_DROP    = 16'sd45;
  localparam logic [CfgW-1:0]        RST_BACKOFF_STEPS  = 16'd500;
  localparam logic [CfgW-1:0]        RST_SEARCH_STEPS   = 16'd10000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PRESET_REST    = 3'd0,
    REG_PRESET_UPRIGHT = 3'd1,
    REG_PRESET_KNOCKED = 3'd2,
    REG_PRESET_DROP    = 3'd3,
    REG_BACKOFF_STEPS  = 3'd4,
    REG_SEARCH_STEPS   = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    KIND_STEP_TICK  = 3'd0,
    KIND_CALIB_TICK = 3'd1,
    KIND_ADD_STEPS  = 3'd2,
    KIND_STOP       = 3'd3,
    KIND_GOTO       = 3'd4,
    KIND_SET_SPEED  = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    STG_IDLE          = 3'd0,
    STG_START         = 3'd1,
    STG_BACKOFF_GO    = 3'd2,
    STG_BACKOFF_STOP  = 3'd3,
    STG_SEARCH_CMD    = 3'd4,
    STG_SEARCH_GO     = 3'd5,
    STG_SEARCH_STOP   = 3'd6
  } stage_t;

  typedef struct packed {
    logic [2:0]                kind;
    logic                      switch_closed;
    logic signed [AmountW-1:0] step_amount;
    logic [1:0]                preset_select;
    logic [PercentW-1:0]       speed_percent;
  } item_t;

  typedef struct packed {
    logic signed [PosW-1:0] preset_rest;
    logic signed [PosW-1:0] preset_upright;
    logic signed [PosW-1:0] preset_knocked;
    logic signed [PosW-1:0] preset_drop;
    logic [CfgW-1:0]        backoff_steps;
    logic [CfgW-1:0]        search_steps;
  } cfg_t;

  typedef struct packed {
    logic signed [RemW-1:0] remaining;
    logic [PosW-1:0]        position;
    logic                   phase_high_next;
    logic                   tick_parity;
    logic                   dir;
    logic                   step;
    logic                   active;
    logic                   calibrating;
    logic                   calibrated;
    stage_t                 stage;
    logic [IntervalW-1:0]   interval;
  } state_t;

endpackage

@@ rtl/sphc_engine.sv @@
// State and update logic of the stepper position and homing controller.
// Applies one word per enabled cycle to the controller state.
// Depends on sphc_pkg.
module sphc_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  sphc_pkg::item_t item,
  input  sphc_pkg::cfg_t  cfg,
  output sphc_pkg::state_t st
);

  sphc_pkg::state_t st_r;
  sphc_pkg::state_t st_nxt;

  // Saturating addition onto the remaining count.
  function automatic logic signed [sphc_pkg::RemW-1:0] sat_add(
    input logic signed [sphc_pkg::RemW-1:0] a,
    input logic signed [sphc_pkg::RemW-1:0] b
  );
    logic signed [sphc_pkg::RemW:0] sum;
    logic signed [sphc_pkg::RemW-1:0] res;
    sum = {a[sphc_pkg::RemW-1], a} + {b[sphc_pkg::RemW-1], b};
    if (sum[sphc_pkg::RemW] != sum[sphc_pkg::RemW-1]) begin
      res = sum[sphc_pkg::RemW] ? sphc_pkg::REM_MIN : sphc_pkg::REM_MAX;
    end else begin
      res = sum[sphc_pkg::RemW-1:0];
    end
    return res;
  endfunction

  always_comb begin
    logic signed [sphc_pkg::RemW-1:0] rem;
    logic signed [sphc_pkg::PosW-1:0] target;
    logic                             low_phase;
    st_nxt    = st_r;
    rem       = st_r.remaining;
    target    = cfg.preset_rest;
    low_phase = 1'b0;
    case (sphc_pkg::kind_t'(item.kind))
      sphc_pkg::KIND_STEP_TICK: begin
        if (st_r.calibrating && item.switch_closed) begin
          rem = '0;
        end
        if (rem != '0) begin
          st_nxt.dir = ~rem[sphc_pkg::RemW-1];
          // A step is made on the low phase of the pulse.
          low_phase = ~st_r.phase_high_next;
          st_nxt.step = st_r.phase_high_next;
          st_nxt.phase_high_next = low_phase;
          if (low_phase) begin
            if (rem[sphc_pkg::RemW-1]) begin
              rem = rem + 18'sd1;
              st_nxt.position = st_r.position - 16'd1;
            end else begin
              rem = rem - 18'sd1;
              st_nxt.position = st_r.position + 16'd1;
            end
          end
        end
        st_nxt.remaining = rem;
        st_nxt.tick_parity = ~st_r.tick_parity;
        if (st_r.tick_parity) begin
          st_nxt.active = (rem != '0);
        end
      end
      sphc_pkg::KIND_CALIB_TICK: begin
        case (st_r.stage)
          sphc_pkg::STG_IDLE: begin
            if (!st_r.calibrated) begin
              st_nxt.stage = sphc_pkg::STG_START;
            end
          end
          sphc_pkg::STG_START: begin
            if (item.switch_closed) begin
              st_nxt.remaining = sat_add(st_r.remaining,
                                         18'sd0 - $signed({2'b00, cfg.backoff_steps}));
              st_nxt.interval  = sphc_pkg::INTERVAL_FAST;
              st_nxt.stage     = sphc_pkg::STG_BACKOFF_GO;
            end else begin
              st_nxt.calibrating = 1'b1;
              st_nxt.stage       = sphc_pkg::STG_SEARCH_CMD;
            end
          end
          sphc_pkg::STG_BACKOFF_GO: begin
            if (st_r.active) begin
              st_nxt.stage = sphc_pkg::STG_BACKOFF_STOP;
            end
          end
          sphc_pkg::STG_BACKOFF_STOP: begin
            if (!st_r.active) begin
              st_nxt.calibrating = 1'b1;
              st_nxt.stage       = sphc_pkg::STG_SEARCH_CMD;
            end
          end
          sphc_pkg::STG_SEARCH_CMD: begin
            st_nxt.remaining = sat_add(st_r.remaining, $signed({2'b00, cfg.search_steps}));
            st_nxt.stage     = sphc_pkg::STG_SEARCH_GO;
          end
          sphc_pkg::STG_SEARCH_GO: begin
            if (st_r.active || item.switch_closed) begin
              st_nxt.stage = sphc_pkg::STG_SEARCH_STOP;
            end
          end
          sphc_pkg::STG_SEARCH_STOP: begin
            if (!st_r.active) begin
              st_nxt.position    = '0;
              st_nxt.calibrating = 1'b0;
              st_nxt.calibrated  = 1'b1;
              st_nxt.remaining   = {{2{cfg.preset_rest[sphc_pkg::PosW-1]}},
                                    cfg.preset_rest};
              st_nxt.stage       = sphc_pkg::STG_IDLE;
            end
          end
          default: begin
            st_nxt.stage = sphc_pkg::STG_IDLE;
          end
        endcase
      end
      sphc_pkg::KIND_ADD_STEPS: begin
        st_nxt.remaining = sat_add(st_r.remaining,
          {item.step_amount[sphc_pkg::AmountW-1], item.step_amount});
      end
      sphc_pkg::KIND_STOP: begin
        st_nxt.remaining = '0;
      end
      sphc_pkg::KIND_GOTO: begin
        case (item.preset_select)
          2'd0:    target = cfg.preset_rest;
          2'd1:    target = cfg.preset_upright;
          2'd2:    target = cfg.preset_knocked;
          default: target = cfg.preset_drop;
        endcase
        st_nxt.remaining = {{2{target[sphc_pkg::PosW-1]}}, target}
                         - {{2{st_r.position[sphc_pkg::PosW-1]}}, st_r.position};
      end
      sphc_pkg::KIND_SET_SPEED: begin
        if (item.speed_percent <= sphc_pkg::SPEED_MAX) begin
          st_nxt.interval = sphc_pkg::INTERVAL_SLOW
            - sphc_pkg::IntervalW'(item.speed_percent) * sphc_pkg::SPEED_STEP;
        end
      end
      default: begin
        st_nxt = st_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.remaining       <= '0;
      st_r.position        <= '0;
      st_r.phase_high_next <= 1'b1;
      st_r.tick_parity     <= 1'b0;
      st_r.dir             <= 1'b1;
      st_r.step            <= 1'b0;
      st_r.active          <= 1'b0;
      st_r.calibrating     <= 1'b0;
      st_r.calibrated      <= 1'b0;
      st_r.stage           <= sphc_pkg::STG_IDLE;
      st_r.interval        <= sphc_pkg::INTERVAL_FAST;
    end else if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st = st_r;

endmodule

@@ rtl/stepper_position_homing_controller_top.sv @@
// Top level of the stepper position and homing controller.
// Holds the handshakes, the input register and the configuration registers.
// Depends on sphc_pkg and sphc_engine.

// The controller takes one word in every clock cycle while results are taken, and gives
// one result word for each: the word is first captured in an input register, and is then
// applied to the controller state, whose registers are also the result register. A result
// that waits for the receiver holds the state, so the input register fills and then
// stalls the sender; as soon as the result is taken, words move again one per cycle.
// Every result shows the state after its word has been handled: step and direction
// levels, absolute position, steps still to go, the moving and homing flags and the
// current step tick interval. Configuration registers (the four preset positions and
// the back-off and search step counts) are written through the plain write port and
// must only be written while no word is in flight.
module stepper_position_homing_controller_top (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // Input channel.
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [2:0]                              in_kind,
  input  logic                                    in_switch_closed,
  input  logic signed [sphc_pkg::AmountW-1:0]     in_step_amount,
  input  logic [1:0]                              in_preset_select,
  input  logic [sphc_pkg::PercentW-1:0]           in_speed_percent,
  // Result channel.
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic                                    out_step_level,
  output logic                                    out_dir_level,
  output logic signed [sphc_pkg::PosW-1:0]        out_position_now,
  output logic signed [sphc_pkg::RemW-1:0]        out_steps_left,
  output logic                                    out_moving,
  output logic                                    out_homed,
  output logic                                    out_homing,
  output logic [sphc_pkg::IntervalW-1:0]          out_tick_interval,
  // Configuration port.
  input  logic                                    cfg_we,
  input  logic [sphc_pkg::CfgIdxW-1:0]            cfg_index,
  input  logic [sphc_pkg::CfgW-1:0]               cfg_wdata
);

  sphc_pkg::item_t  in_item_r;
  logic             in_full_r;
  logic             out_valid_r;
  sphc_pkg::cfg_t   cfg_r;
  sphc_pkg::state_t st;
  logic             advance;

  // The word in the input register moves on when the result slot is empty or being taken.
  assign advance  = in_full_r && (!out_valid_r || !out_stall);
  assign in_stall = in_full_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_full_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The payload of the input register needs no reset.
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item_r.kind          <= in_kind;
      in_item_r.switch_closed <= in_switch_closed;
      in_item_r.step_amount   <= in_step_amount;
      in_item_r.preset_select <= in_preset_select;
      in_item_r.speed_percent <= in_speed_percent;
    end
  end

  // Configuration registers; writes to an index beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.preset_rest    <= sphc_pkg::RST_PRESET_REST;
      cfg_r.preset_upright <= sphc_pkg::RST_PRESET_UPRIGHT;
      cfg_r.preset_knocked <= sphc_pkg::RST_PRESET_KNOCKED;
      cfg_r.preset_drop    <= sphc_pkg::RST_PRESET_DROP;
      cfg_r.backoff_steps  <= sphc_pkg::RST_BACKOFF_STEPS;
      cfg_r.search_steps   <= sphc_pkg::RST_SEARCH_STEPS;
    end else if (cfg_we) begin
      case (sphc_pkg::reg_idx_t'(cfg_index))
        sphc_pkg::REG_PRESET_REST:    cfg_r.preset_rest    <= cfg_wdata;
        sphc_pkg::REG_PRESET_UPRIGHT: cfg_r.preset_upright <= cfg_wdata;
        sphc_pkg::REG_PRESET_KNOCKED: cfg_r.preset_knocked <= cfg_wdata;
        sphc_pkg::REG_PRESET_DROP:    cfg_r.preset_drop    <= cfg_wdata;
        sphc_pkg::REG_BACKOFF_STEPS:  cfg_r.backoff_steps  <= cfg_wdata;
        sphc_pkg::REG_SEARCH_STEPS:   cfg_r.search_steps   <= cfg_wdata;
        default:                      cfg_r                <= cfg_r;
      endcase
    end
  end

  // The state changes only when a word advances, so it holds while a result is stalled.
  sphc_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .item  (in_item_r),
    .cfg   (cfg_r),
    .st    (st)
  );

  assign out_valid         = out_valid_r;
  assign out_step_level    = st.step;
  assign out_dir_level     = st.dir;
  assign out_position_now  = st.position;
  assign out_steps_left    = st.remaining;
  assign out_moving        = st.active;
  assign out_homed         = st.calibrated;
  assign out_homing        = st.calibrating;
  assign out_tick_interval = st.interval;

endmodule
